FILE: hdl/afc_pkg.sv
package afc_pkg;

    // Field widths
    localparam int COORD_W  = 24;   // Q20.4 position and box bounds
    localparam int SCALE_W  = 16;   // Q8.8 scale
    localparam int NORMAL_W = 14;   // Q2.12 plane normal component
    localparam int OFFSET_W = 22;   // Q18.4 plane offset
    localparam int AXES     = 3;

    // Fraction alignment
    localparam int SCALE_FRAC  = 8;
    localparam int NORMAL_FRAC = 12;
    localparam int DIST_SHIFT  = SCALE_FRAC + NORMAL_FRAC;

    // Exact intermediate widths
    localparam int PROD1_W  = COORD_W + SCALE_W;        // box * scale
    localparam int CORNER_W = PROD1_W + 1;              // + pos << 8
    localparam int PROD2_W  = CORNER_W + NORMAL_W;      // normal * corner
    localparam int DIST_W   = PROD2_W + 2;              // three terms + offset

    // Plane register layout
    localparam int PLANE_W    = 64;
    localparam int OFFSET_LSB = AXES * NORMAL_W;
    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W  = $clog2(PLANE_REGS);
    localparam int NUM_PLANES_DEF = 6;

    // Stream widths
    localparam int IN_DATA_W  = 4 * AXES * COORD_W - AXES * (COORD_W - SCALE_W);
    localparam int OUT_DATA_W = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SCALE_W-1:0] scale_t;

    // One box transaction, axis 0 = x in the low element
    typedef struct packed {
        coord_t [AXES-1:0] hi;
        coord_t [AXES-1:0] lo;
        scale_t [AXES-1:0] scale;
        coord_t [AXES-1:0] pos;
    } box_t;

    // Per-stage load enables shared by all lanes
    typedef struct packed {
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } stage_en_t;

endpackage

FILE: hdl/afc_lane.sv
module afc_lane (
    input  logic                            aclk,
    input  logic [afc_pkg::PLANE_W-1:0]     plane,
    input  afc_pkg::box_t                   box,
    input  afc_pkg::stage_en_t              en,
    output logic                            lane_neg
);

    logic signed [afc_pkg::PROD1_W-1:0]  prod1_reg   [afc_pkg::AXES];
    logic signed [afc_pkg::PROD1_W-1:0]  prod1_next  [afc_pkg::AXES];
    logic signed [afc_pkg::COORD_W-1:0]  pos_reg     [afc_pkg::AXES];
    logic signed [afc_pkg::CORNER_W-1:0] corner_reg  [afc_pkg::AXES];
    logic signed [afc_pkg::CORNER_W-1:0] corner_next [afc_pkg::AXES];
    logic signed [afc_pkg::PROD2_W-1:0]  prod2_reg   [afc_pkg::AXES];
    logic signed [afc_pkg::PROD2_W-1:0]  prod2_next  [afc_pkg::AXES];
    logic signed [afc_pkg::NORMAL_W-1:0] normal      [afc_pkg::AXES];
    logic signed [afc_pkg::OFFSET_W-1:0] offset;
    logic signed [afc_pkg::DIST_W-1:0]   dist_next;
    logic                                neg_reg;

    assign offset = $signed(plane[afc_pkg::OFFSET_LSB +: afc_pkg::OFFSET_W]);

    always_comb begin
        for (int a = 0; a < afc_pkg::AXES; a++) begin
            normal[a] = $signed(plane[a*afc_pkg::NORMAL_W +: afc_pkg::NORMAL_W]);
            // p-vertex: min bound where the normal points negative
            prod1_next[a] = (normal[a] < 0)
                ? afc_pkg::PROD1_W'($signed(box.lo[a])) *
                  afc_pkg::PROD1_W'($signed(box.scale[a]))
                : afc_pkg::PROD1_W'($signed(box.hi[a])) *
                  afc_pkg::PROD1_W'($signed(box.scale[a]));
            corner_next[a] = afc_pkg::CORNER_W'(prod1_reg[a]) +
                (afc_pkg::CORNER_W'(pos_reg[a]) <<< afc_pkg::SCALE_FRAC);
            prod2_next[a] = afc_pkg::PROD2_W'(normal[a]) *
                afc_pkg::PROD2_W'(corner_reg[a]);
        end
        dist_next = afc_pkg::DIST_W'(prod2_reg[0]) + afc_pkg::DIST_W'(prod2_reg[1]) +
                    afc_pkg::DIST_W'(prod2_reg[2]) +
                    (afc_pkg::DIST_W'(offset) <<< afc_pkg::DIST_SHIFT);
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < afc_pkg::AXES; a++) begin
            if (en.s1) begin
                prod1_reg[a] <= prod1_next[a];
                pos_reg[a]   <= $signed(box.pos[a]);
            end
            if (en.s2) begin
                corner_reg[a] <= corner_next[a];
            end
            if (en.s3) begin
                prod2_reg[a] <= prod2_next[a];
            end
        end
        if (en.s4) begin
            neg_reg <= dist_next[afc_pkg::DIST_W-1];
        end
    end

    assign lane_neg = neg_reg;

endmodule

FILE: hdl/afc_merge.sv
module afc_merge #(
    parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [NUM_PLANES-1:0] lane_neg,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic                  out_culled,
    input  logic                  out_ready
);

    logic valid_reg;
    logic valid_next;
    logic culled_reg;
    logic culled_next;

    assign in_ready    = !valid_reg || out_ready;
    assign valid_next  = in_ready ? in_valid : valid_reg;
    assign culled_next = |lane_neg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            culled_reg <= culled_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_culled = culled_reg;

endmodule

FILE: hdl/aabb_frustum_cull.sv
// aabb_frustum_cull: p-vertex box test against up to six frustum planes.
// Path from s_ accept to m_ accept: 4 lane stages (s1 to s4), then the merge output
// register, which drives m_tvalid.
// Throughput: one box per cycle while m_tready is high; else the stall chain lets a new
// box in while any stage is empty. One lane per plane, all in parallel, sets the rate.
// Reset (aresetn low, synchronous): planes cleared (nothing culled), pipeline emptied.
module aabb_frustum_cull #(
    parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // box stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [afc_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fields from bit 0: culled, then zero fill
    output logic [afc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // plane writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]       cfg_data
);

    // Plane registers: normal x/y/z in bits 41:0, offset in 63:42
    logic [afc_pkg::PLANE_W-1:0] plane_reg [afc_pkg::PLANE_REGS];

    // Pipeline occupancy, one flag per lane stage
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    afc_pkg::stage_en_t en;
    afc_pkg::box_t      box;
    logic               merge_ready;
    logic               culled;
    logic [NUM_PLANES-1:0] lane_neg;

    assign cfg_ready = 1'b1;

    // Writes past the last plane are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < afc_pkg::PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready &&
                     cfg_index < afc_pkg::CFG_IDX_W'(afc_pkg::PLANE_REGS)) begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // Stage loads when empty or when its contents move on: bubbles collapse
    assign en.s4 = !v4_reg || merge_ready;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;
    assign s_tready = en.s1;

    assign v1_next = en.s1 ? s_tvalid : v1_reg;
    assign v2_next = en.s2 ? v1_reg   : v2_reg;
    assign v3_next = en.s3 ? v2_reg   : v3_reg;
    assign v4_next = en.s4 ? v3_reg   : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign box = afc_pkg::box_t'(s_tdata);

    // One lane per plane under test
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        afc_lane u_lane (
            .aclk     (aclk),
            .plane    (plane_reg[p]),
            .box      (box),
            .en       (en),
            .lane_neg (lane_neg[p])
        );
    end

    // Any plane with the p-vertex behind it culls the box
    afc_merge #(
        .NUM_PLANES (NUM_PLANES)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lane_neg   (lane_neg),
        .in_valid   (v4_reg),
        .in_ready   (merge_ready),
        .out_valid  (m_tvalid),
        .out_culled (culled),
        .out_ready  (m_tready)
    );

    assign m_tdata = afc_pkg::OUT_DATA_W'(culled);

`ifndef ASSERT_OFF
    // Input backs up only when every stage, output register included, holds a transaction
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && m_tvalid && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    // A transaction leaving the last lane stage shows up at the output
    a_merge_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && merge_ready) |=> m_tvalid)
        else $error("lane result lost at merge stage");

    // An accepted box reaches stage one
    a_stage1_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted box not captured");
`endif

endmodule
